// ----- rtl/i2r_pkg.sv -----
// ----------------------------------------------------------------------------
// i2r_pkg - shared types and tables of the integer-to-Roman encoder
// Symbol table of the greedy encoder, sequencer states and the structs that
// pass between the sequencer and the shared compare/subtract unit.
// ----------------------------------------------------------------------------
package i2r_pkg;

    localparam int unsigned VALUE_W = 13;
    localparam int unsigned SYM_W   = 7;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned STEP_W  = 10;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 13'd4999;
    localparam logic [IDX_W-1:0]   LAST_IDX  = 4'd12;

    // ASCII codes of the Roman digits
    localparam logic [SYM_W-1:0] SYM_M    = 7'h4D;
    localparam logic [SYM_W-1:0] SYM_D    = 7'h44;
    localparam logic [SYM_W-1:0] SYM_C    = 7'h43;
    localparam logic [SYM_W-1:0] SYM_L    = 7'h4C;
    localparam logic [SYM_W-1:0] SYM_X    = 7'h58;
    localparam logic [SYM_W-1:0] SYM_V    = 7'h56;
    localparam logic [SYM_W-1:0] SYM_I    = 7'h49;
    localparam logic [SYM_W-1:0] SYM_NONE = 7'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ERR
    } seq_state_t;

    // One row of the greedy table: weight, leading symbol, trailing symbol
    // of a subtractive pair, and whether the row is a pair.
    typedef struct packed {
        logic [STEP_W-1:0] weight;
        logic [SYM_W-1:0]  sym_first;
        logic [SYM_W-1:0]  sym_second;
        logic              pair;
    } step_row_t;

    // Request to the shared unit
    typedef struct packed {
        logic [VALUE_W-1:0] remain;
        logic [IDX_W-1:0]   idx;
    } unit_req_t;

    // Answer of the shared unit
    typedef struct packed {
        logic               fits;
        logic [VALUE_W-1:0] diff;
        logic               diff_zero;
        logic [SYM_W-1:0]   sym_first;
        logic [SYM_W-1:0]   sym_second;
        logic               pair;
    } unit_rsp_t;

    function automatic step_row_t step_row(input logic [IDX_W-1:0] idx);
        step_row_t row;
        unique case (idx)
            4'd0:    row = '{10'd1000, SYM_M, SYM_NONE, 1'b0};
            4'd1:    row = '{10'd900,  SYM_C, SYM_M,    1'b1};
            4'd2:    row = '{10'd500,  SYM_D, SYM_NONE, 1'b0};
            4'd3:    row = '{10'd400,  SYM_C, SYM_D,    1'b1};
            4'd4:    row = '{10'd100,  SYM_C, SYM_NONE, 1'b0};
            4'd5:    row = '{10'd90,   SYM_X, SYM_C,    1'b1};
            4'd6:    row = '{10'd50,   SYM_L, SYM_NONE, 1'b0};
            4'd7:    row = '{10'd40,   SYM_X, SYM_L,    1'b1};
            4'd8:    row = '{10'd10,   SYM_X, SYM_NONE, 1'b0};
            4'd9:    row = '{10'd9,    SYM_I, SYM_X,    1'b1};
            4'd10:   row = '{10'd5,    SYM_V, SYM_NONE, 1'b0};
            4'd11:   row = '{10'd4,    SYM_I, SYM_V,    1'b1};
            default: row = '{10'd1,    SYM_I, SYM_NONE, 1'b0};
        endcase
        return row;
    endfunction

endpackage

// ----- rtl/integer_to_roman_encoder.sv -----
// ----------------------------------------------------------------------------
// integer_to_roman_encoder - binary value to Roman numeral symbol stream
// Converts each request value into ASCII Roman symbols, most significant
// first, with tlast on the final symbol of the run.
// ----------------------------------------------------------------------------
// Usage
//   Slave side takes one request per value (tdata[12:0]). Master side gives
//   one request per symbol: tdata[6:0] is the ASCII code, tlast marks the
//   final symbol of a run, tuser flags an out-of-range value (0 or above
//   4999), which yields a single request with symbol 0, tlast and tuser set.
//   Symbols follow the greedy table M, CM, D, CD, C, XC, L, XL, X, IX, V,
//   IV, I, walked one step a cycle by a single shared compare/subtract unit
//   while the receiver does not stall: each such cycle either emits one
//   symbol or moves to the next table row, so each row skipped delays the
//   next symbol. Later symbols follow one a cycle with no stall when no row
//   is skipped between them. A run makes up to twelve row advances besides
//   its symbols; the longest run (4888) is 16 symbols. s_axis_tready is
//   high only while idle.
//   When the receiver stalls, the symbol in the output register holds and
//   the sequencer waits. Reset drops any run in progress, empties the
//   output register and returns the block to idle.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [12:0] value, [15:13] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] symbol, [7] zero
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] error
);

    i2r_pkg::unit_req_t           unit_req;
    i2r_pkg::unit_rsp_t           unit_rsp;
    logic [i2r_pkg::SYM_W-1:0]    symbol;

    // shared compare/subtract unit
    i2r_unit u_unit (
        .req (unit_req),
        .rsp (unit_rsp)
    );

    // sequencer, holds the run state and the output register
    i2r_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_value   (s_axis_tdata[i2r_pkg::VALUE_W-1:0]),
        .unit_req   (unit_req),
        .unit_rsp   (unit_rsp),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_symbol (symbol),
        .out_last   (m_axis_tlast),
        .out_error  (m_axis_tuser)
    );

    // pad the symbol to a whole byte
    assign m_axis_tdata = {1'b0, symbol};

endmodule

// ----- rtl/i2r_unit.sv -----
// ----------------------------------------------------------------------------
// i2r_unit - shared compare/subtract unit
// Looks up the current table row and compares and subtracts its weight
// from the remaining value.
// ----------------------------------------------------------------------------
module i2r_unit (
    input  i2r_pkg::unit_req_t req,
    output i2r_pkg::unit_rsp_t rsp
);

    i2r_pkg::step_row_t             row;
    logic [i2r_pkg::VALUE_W-1:0]    weight_ext;
    logic [i2r_pkg::VALUE_W:0]      sub;

    always_comb
    begin
        row        = i2r_pkg::step_row(req.idx);
        weight_ext = {{(i2r_pkg::VALUE_W - i2r_pkg::STEP_W){1'b0}}, row.weight};
        sub        = {1'b0, req.remain} - {1'b0, weight_ext};

        rsp.fits       = ~sub[i2r_pkg::VALUE_W];
        rsp.diff       = sub[i2r_pkg::VALUE_W-1:0];
        rsp.diff_zero  = (sub[i2r_pkg::VALUE_W-1:0] == '0);
        rsp.sym_first  = row.sym_first;
        rsp.sym_second = row.sym_second;
        rsp.pair       = row.pair;
    end

endmodule

// ----- rtl/i2r_seq.sv -----
// ----------------------------------------------------------------------------
// i2r_seq - encoder sequencer and output register
// Walks the greedy table one step a cycle (waiting while the receiver stalls)
// via the shared unit; holds each symbol in the output register till taken.
// ----------------------------------------------------------------------------
module i2r_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [i2r_pkg::VALUE_W-1:0]    in_value,
    output i2r_pkg::unit_req_t             unit_req,
    input  i2r_pkg::unit_rsp_t             unit_rsp,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [i2r_pkg::SYM_W-1:0]      out_symbol,
    output logic                           out_last,
    output logic                           out_error
);

    i2r_pkg::seq_state_t state_reg, state_next;

    logic [i2r_pkg::VALUE_W-1:0] remain_reg, remain_next;
    logic [i2r_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                        half_reg, half_next;

    logic                        ovalid_reg, ovalid_next;
    logic [i2r_pkg::SYM_W-1:0]   osym_reg, osym_next;
    logic                        olast_reg, olast_next;
    logic                        oerr_reg, oerr_next;

    logic accept;
    logic bad_value;
    logic slot_free;
    logic emit;
    logic emit_last;
    logic [i2r_pkg::SYM_W-1:0] emit_sym;

    assign accept    = in_valid && in_ready;
    assign bad_value = (in_value == '0) || (in_value > i2r_pkg::MAX_VALUE);
    assign slot_free = !ovalid_reg || out_ready;

    assign unit_req.remain = remain_reg;
    assign unit_req.idx    = idx_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            i2r_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bad_value ? i2r_pkg::ST_ERR : i2r_pkg::ST_RUN;
                end
            end
            i2r_pkg::ST_RUN:
            begin
                if (emit && emit_last)
                begin
                    state_next = i2r_pkg::ST_IDLE;
                end
            end
            i2r_pkg::ST_ERR:
            begin
                if (slot_free)
                begin
                    state_next = i2r_pkg::ST_IDLE;
                end
            end
            default: state_next = i2r_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready    = 1'b0;
        emit        = 1'b0;
        emit_last   = 1'b0;
        emit_sym    = i2r_pkg::SYM_NONE;
        remain_next = remain_reg;
        idx_next    = idx_reg;
        half_next   = half_reg;
        unique case (state_reg)
            i2r_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    remain_next = in_value;
                    idx_next    = '0;
                    half_next   = 1'b0;
                end
            end
            i2r_pkg::ST_RUN:
            begin
                if (slot_free)
                begin
                    priority if (half_reg)
                    begin
                        // trailing symbol of a pair: retire its weight
                        emit        = 1'b1;
                        emit_sym    = unit_rsp.sym_second;
                        emit_last   = unit_rsp.diff_zero;
                        remain_next = unit_rsp.diff;
                        half_next   = 1'b0;
                    end
                    else if (unit_rsp.fits)
                    begin
                        emit     = 1'b1;
                        emit_sym = unit_rsp.sym_first;
                        if (unit_rsp.pair)
                        begin
                            half_next = 1'b1;
                        end
                        else
                        begin
                            emit_last   = unit_rsp.diff_zero;
                            remain_next = unit_rsp.diff;
                        end
                    end
                    else if (idx_reg != i2r_pkg::LAST_IDX)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            i2r_pkg::ST_ERR:
            begin
                emit      = slot_free;
                emit_last = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // output register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        osym_next   = osym_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;
        if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
        if (emit)
        begin
            ovalid_next = 1'b1;
            osym_next   = emit_sym;
            olast_next  = emit_last;
            oerr_next   = (state_reg == i2r_pkg::ST_ERR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= i2r_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
            half_reg   <= 1'b0;
            idx_reg    <= '0;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            half_reg   <= half_next;
            idx_reg    <= idx_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        osym_reg  <= osym_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    assign out_valid  = ovalid_reg;
    assign out_symbol = osym_reg;
    assign out_last   = olast_reg;
    assign out_error  = oerr_reg;

endmodule
